// ===== design/iws_pkg.sv =====
// ============================================================================
// iws_pkg
// Shared constants, byte classes and judge result type of the word splitter.
// ============================================================================
package iws_pkg;

	localparam int DEF_MAX_WORD_LENGTH = 63;
	localparam int LEN_CAP             = 63;  // store and word_length hold no more
	localparam int LEN_W               = 7;   // length counts to one past the limit
	localparam int CFG_W               = 6;
	localparam int CFG_IDX_W           = 1;
	localparam int CHUNK_W             = 64;
	localparam int CHUNK_BYTES_W       = 4;
	localparam int WORD_LEN_W          = 6;
	localparam int CHUNK_IDX_W         = 3;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_WORD_LENGTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LETTER_COUNT = 1'b1;
	localparam logic [CFG_W-1:0]     MIN_WORD_LENGTH_RST  = 6'd2;
	localparam logic [CFG_W-1:0]     MIN_LETTER_COUNT_RST = 6'd2;

	typedef struct packed {
		logic do_close;   // close the open word before anything else
		logic do_append;  // append the judged byte afterwards
	} judge_t;

	function automatic logic is_capital(input logic [7:0] c);
		return (c >= 8'h41) && (c <= 8'h5A);
	endfunction

	function automatic logic is_lower(input logic [7:0] c);
		return (c >= 8'h61) && (c <= 8'h7A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	// top-bit bytes count as letters
	function automatic logic is_letter(input logic [7:0] c);
		return is_lower(c) || is_capital(c) || c[7];
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return is_letter(c) || is_digit(c);
	endfunction

	function automatic logic [7:0] to_lower(input logic [7:0] c);
		return is_capital(c) ? (c | 8'h20) : c;
	endfunction

endpackage

// ===== design/iws_ram.sv =====
// ============================================================================
// iws_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ============================================================================
module iws_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/iws_judge.sv =====
// ============================================================================
// iws_judge
// Word boundary decision for one byte, given its neighbours.
// ============================================================================
module iws_judge (
	input  logic          en,         // a byte is judged in this phase
	input  logic          flush,      // closing phase at end of identifier
	input  logic          word_open,  // a word is open
	input  logic [7:0]    cur,
	input  logic [7:0]    prev,
	input  logic          has_next,
	input  logic [7:0]    nxt,
	output iws_pkg::judge_t res
);
	import iws_pkg::*;

	logic alnum;
	logic split;

	always_comb begin
		alnum = is_alnum(cur);
		// capital after lower/digit, or capital in a capital run before a lower
		split = word_open && is_capital(cur) &&
			(is_lower(prev) || is_digit(prev) ||
			 (is_capital(prev) && has_next && is_lower(nxt)));
		res.do_close  = flush ? word_open : (en && (alnum ? split : word_open));
		res.do_append = en && alnum && !flush;
	end

endmodule

// ===== design/identifier_word_splitter_core.sv =====
// ============================================================================
// identifier_word_splitter_core
// Splits identifier bytes into lowercased words, emitted in 8-byte chunks.
// ============================================================================
// Usage
//  - in channel: one byte (ch) per item, end_of_identifier on the final byte.
//    in_ready is high only while the sequencer is idle; one item is handled
//    at a time.
//  - out channel: one chunk per item, up to 8 bytes, first byte in bits 7..0,
//    with chunk_bytes, the word's total word_length and last_chunk.
//  - cfg port: cfg_we/cfg_index/cfg_data, index 0 min_word_length, index 1
//    min_letter_count; write only while idle.
//  - Steps: a byte that closes no word passes through judge, append and
//    idle. The final byte of an identifier adds steps for judging it and
//    closing the open word. Every chunk adds a row read step and an output
//    load, as long as the receiver keeps out_ready high.
//  - The word store holds full 8-byte rows; the newest row also sits in a
//    row buffer that gives the last chunk; others are single memory reads.
//  - A stalled receiver holds the sequencer in the output load step; the
//    last chunk of a word frees it at once, so the next byte can be taken
//    while that chunk still waits in the output register.
//  - Reset clears all control state and restores both limits to 2; the
//    word store is not cleared, only rows written for the open word are read.
// ============================================================================
module identifier_word_splitter_core #(
	parameter int MAX_WORD_LENGTH = iws_pkg::DEF_MAX_WORD_LENGTH
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input bytes
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [7:0]                            ch,
	input  logic                                  end_of_identifier,
	// word chunks
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [iws_pkg::CHUNK_W-1:0]           chunk,
	output logic [iws_pkg::CHUNK_BYTES_W-1:0]     chunk_bytes,
	output logic [iws_pkg::WORD_LEN_W-1:0]        word_length,
	output logic                                  last_chunk,
	// configuration
	input  logic                                  cfg_we,
	input  logic [iws_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [iws_pkg::CFG_W-1:0]             cfg_data
);
	import iws_pkg::*;

	// longest kept word, limited by the store and the word_length field
	localparam int LIMIT = (MAX_WORD_LENGTH < LEN_CAP) ? MAX_WORD_LENGTH : LEN_CAP;
	localparam int ROWS  = (LIMIT + 7) / 8;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam logic [LEN_W-1:0] LIMIT_L = LEN_W'(LIMIT);

	typedef enum logic [2:0] {
		S_IDLE,
		S_JUDGE,
		S_RD,
		S_LD,
		S_APPEND
	} state_t;

	// judging phases: held byte, then final byte and final close at identifier end
	typedef enum logic [1:0] {
		PH_HELD,
		PH_FINAL,
		PH_CLOSE
	} phase_t;

	state_t state_q;
	phase_t phase_q;

	// item being worked on
	logic [7:0]             cur_q;
	logic                   last_q;
	// hold-back state
	logic [7:0]             held_q;
	logic                   held_valid_q;
	logic [7:0]             before_held_q;
	// open word
	logic                   inside_q;
	logic [LEN_W-1:0]       word_len_q;
	logic [LEN_W-1:0]       letters_q;
	logic [CHUNK_W-1:0]     row_buf_q;
	logic                   append_pend_q;
	logic [CHUNK_IDX_W-1:0] chunk_idx_q;
	// limits
	logic [CFG_W-1:0]       min_len_q;
	logic [CFG_W-1:0]       min_let_q;
	// output register
	logic                      out_valid_q;
	logic [CHUNK_W-1:0]        chunk_q;
	logic [CHUNK_BYTES_W-1:0]  chunk_bytes_q;
	logic [WORD_LEN_W-1:0]     word_length_q;
	logic                      last_chunk_q;

	// judge inputs
	judge_t      jres;
	logic        judge_en;
	logic [7:0]  judge_byte;

	// append path
	logic [7:0]         app_byte;
	logic [CHUNK_W-1:0] buf_next;
	logic               ram_we;

	// emission path
	logic [LEN_W-1:0]          len_m1;
	logic [CHUNK_IDX_W-1:0]    last_idx;
	logic                      at_last;
	logic                      keep_word;
	logic                      out_free;
	logic                      ram_re;
	logic [CHUNK_W-1:0]        ram_rdata;
	logic [CHUNK_BYTES_W-1:0]  cur_bytes;

	always_comb begin
		judge_en   = ((phase_q == PH_HELD) && held_valid_q) || (phase_q == PH_FINAL);
		judge_byte = (phase_q == PH_HELD) ? held_q : cur_q;
	end

	iws_judge u_judge (
		.en       (judge_en),
		.flush    (phase_q == PH_CLOSE),
		.word_open(inside_q),
		.cur      (judge_byte),
		.prev     (before_held_q),
		.has_next (phase_q == PH_HELD),
		.nxt      (cur_q),
		.res      (jres)
	);

	always_comb begin
		app_byte = to_lower(judge_byte);
		// a new row starts clean, so bytes past the word end read as zero
		if (word_len_q[2:0] == 3'd0) begin
			buf_next = CHUNK_W'(app_byte);
		end else begin
			buf_next = row_buf_q | (CHUNK_W'(app_byte) << {word_len_q[2:0], 3'b000});
		end
		// full rows go to the store; the partial row stays in the buffer
		ram_we = (state_q == S_APPEND) && append_pend_q &&
			(word_len_q < LIMIT_L) && (word_len_q[2:0] == 3'd7);

		len_m1    = word_len_q - LEN_W'(1);
		last_idx  = len_m1[5:3];
		at_last   = (chunk_idx_q == last_idx);
		keep_word = inside_q && (word_len_q >= {1'b0, min_len_q}) &&
			(word_len_q <= LIMIT_L) && (letters_q >= {1'b0, min_let_q});
		out_free  = !out_valid_q || out_ready;
		ram_re    = (state_q == S_RD) && !at_last;
		cur_bytes = at_last ? (CHUNK_BYTES_W'(len_m1[2:0]) + CHUNK_BYTES_W'(1))
			: CHUNK_BYTES_W'(8);
	end

	iws_ram #(
		.WIDTH (CHUNK_W),
		.DEPTH (ROWS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ROW_W'(word_len_q[5:3])),
		.wdata (buf_next),
		.re    (ram_re),
		.raddr (ROW_W'(chunk_idx_q)),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			phase_q       <= PH_HELD;
			last_q        <= 1'b0;
			held_q        <= 8'd0;
			held_valid_q  <= 1'b0;
			before_held_q <= 8'd0;
			inside_q      <= 1'b0;
			word_len_q    <= '0;
			letters_q     <= '0;
			append_pend_q <= 1'b0;
			chunk_idx_q   <= '0;
			min_len_q     <= MIN_WORD_LENGTH_RST;
			min_let_q     <= MIN_LETTER_COUNT_RST;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MIN_WORD_LENGTH:  min_len_q <= cfg_data;
					REG_MIN_LETTER_COUNT: min_let_q <= cfg_data;
					default: ;
				endcase
			end

			// a load in the same cycle refills the register instead
			if (out_valid_q && out_ready && (state_q != S_LD)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cur_q   <= ch;
						last_q  <= end_of_identifier;
						phase_q <= PH_HELD;
						state_q <= S_JUDGE;
					end
				end

				S_JUDGE: begin
					append_pend_q <= jres.do_append;
					chunk_idx_q   <= '0;
					if (jres.do_close && keep_word) begin
						state_q <= S_RD;
					end else begin
						if (jres.do_close) begin
							inside_q   <= 1'b0;
							word_len_q <= '0;
							letters_q  <= '0;
						end
						state_q <= S_APPEND;
					end
				end

				// row read issued combinationally; last chunk comes from the buffer
				S_RD: begin
					state_q <= S_LD;
				end

				S_LD: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						chunk_q       <= at_last ? row_buf_q : ram_rdata;
						chunk_bytes_q <= cur_bytes;
						word_length_q <= word_len_q[WORD_LEN_W-1:0];
						last_chunk_q  <= at_last;
						chunk_idx_q   <= chunk_idx_q + CHUNK_IDX_W'(1);
						if (at_last) begin
							inside_q   <= 1'b0;
							word_len_q <= '0;
							letters_q  <= '0;
							state_q    <= S_APPEND;
						end else begin
							state_q <= S_RD;
						end
					end
				end

				S_APPEND: begin
					if (append_pend_q) begin
						inside_q <= 1'b1;
						if (word_len_q <= LIMIT_L) begin
							if (word_len_q < LIMIT_L) begin
								row_buf_q <= buf_next;
							end
							if (is_letter(app_byte)) begin
								letters_q <= letters_q + LEN_W'(1);
							end
							word_len_q <= word_len_q + LEN_W'(1);
						end
					end
					append_pend_q <= 1'b0;
					case (phase_q)
						PH_HELD: begin
							before_held_q <= held_valid_q ? held_q : 8'd0;
							held_q        <= cur_q;
							held_valid_q  <= 1'b1;
							if (last_q) begin
								phase_q <= PH_FINAL;
								state_q <= S_JUDGE;
							end else begin
								state_q <= S_IDLE;
							end
						end
						PH_FINAL: begin
							phase_q <= PH_CLOSE;
							state_q <= S_JUDGE;
						end
						PH_CLOSE: begin
							held_q        <= 8'd0;
							held_valid_q  <= 1'b0;
							before_held_q <= 8'd0;
							phase_q       <= PH_HELD;
							state_q       <= S_IDLE;
						end
						default: begin
							phase_q <= PH_HELD;
							state_q <= S_IDLE;
						end
					endcase
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign chunk       = chunk_q;
	assign chunk_bytes = chunk_bytes_q;
	assign word_length = word_length_q;
	assign last_chunk  = last_chunk_q;

endmodule

// ===== design/iws_checker.sv =====
// ============================================================================
// iws_checker
// Port-level checks on the chunk stream of the word splitter.
// ============================================================================
module iws_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic [iws_pkg::CHUNK_W-1:0]           chunk,
	input logic [iws_pkg::CHUNK_BYTES_W-1:0]     chunk_bytes,
	input logic [iws_pkg::WORD_LEN_W-1:0]        word_length,
	input logic                                  last_chunk
);
	import iws_pkg::*;

	// stalled item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(chunk) &&
		$stable(chunk_bytes) && $stable(last_chunk))
		else $error("stalled chunk changed");

	// inner chunks are always full
	a_inner_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_chunk |-> chunk_bytes == CHUNK_BYTES_W'(8))
		else $error("inner chunk not full");

	// final chunk carries the remainder of the word length
	a_last_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_chunk |->
		(chunk_bytes == {1'b0, word_length[2:0]}) ||
		((word_length[2:0] == 3'd0) && (chunk_bytes == CHUNK_BYTES_W'(8))))
		else $error("last chunk size disagrees with word length");

	// chunks of one word agree on its length
	a_same_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_chunk ##1 out_valid |->
		word_length == $past(word_length))
		else $error("word length changed inside a word");

endmodule

bind identifier_word_splitter_core iws_checker u_iws_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.chunk       (chunk),
	.chunk_bytes (chunk_bytes),
	.word_length (word_length),
	.last_chunk  (last_chunk)
);

// ===== test/identifier_word_splitter_core_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// identifier_word_splitter_core_tb
// Drives identifier bytes into the splitter under random back-pressure and
// compares every word chunk against a bit-true software copy of the splitter.
// ============================================================================
module identifier_word_splitter_core_tb;
	import iws_pkg::*;

	// words past this length are dropped whole
	localparam int WORD_CAP = (DEF_MAX_WORD_LENGTH < LEN_CAP) ? DEF_MAX_WORD_LENGTH : LEN_CAP;
	localparam int MAX_CHUNKS_PER_ITEM = 16;
	localparam int SETTLE_CYCLES       = 16;   // room for judging the final byte and the close
	localparam int DRAIN_LIMIT         = 5000;
	localparam int CYCLE_LIMIT         = 500000;
	localparam int IDLE_PCT            = 38;
	localparam int REPORT_LIMIT        = 10;

	typedef logic [7:0] byte_seq_t [$];

	typedef struct packed {
		logic [CHUNK_W-1:0]       data;
		logic [CHUNK_BYTES_W-1:0] nbytes;
		logic [WORD_LEN_W-1:0]    wlen;
		logic                     last;
	} chunk_rec_t;

	// shapes of a word inside a generated identifier
	typedef enum int {
		RUN_LOWER,    // fooo
		RUN_TITLE,    // Fooo
		RUN_ACRONYM,  // FOOO
		RUN_DIGITS,   // 1234
		RUN_MIXED     // any alphanumeric, high bytes included
	} run_style_t;

	logic                     clk               = 1'b0;
	logic                     arst_n            = 1'b0;
	logic                     in_valid          = 1'b0;
	logic                     in_ready;
	logic [7:0]               ch                = 8'h00;
	logic                     end_of_identifier = 1'b0;
	logic                     out_valid;
	logic                     out_ready         = 1'b0;
	logic [CHUNK_W-1:0]       chunk;
	logic [CHUNK_BYTES_W-1:0] chunk_bytes;
	logic [WORD_LEN_W-1:0]    word_length;
	logic                     last_chunk;
	logic                     cfg_we            = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index         = REG_MIN_WORD_LENGTH;
	logic [CFG_W-1:0]         cfg_data          = '0;

	// when set, neither side idles
	bit steady_flow = 1'b0;
	int fault_count = 0;
	int cycle_count = 0;

	chunk_rec_t expected_chunks [$];

	// splitter copy: open word, held-back byte and limits
	logic [7:0] word_bytes [64];
	int         open_len        = 0;
	int         open_letters    = 0;
	logic [7:0] held            = 8'h00;
	bit         held_ok         = 1'b0;
	logic [7:0] prev_held       = 8'h00;
	bit         in_word         = 1'b0;
	int         cfg_min_len     = int'(MIN_WORD_LENGTH_RST);
	int         cfg_min_letters = int'(MIN_LETTER_COUNT_RST);
	int         chunks_this_item;

	identifier_word_splitter_core i_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.ch                (ch),
		.end_of_identifier (end_of_identifier),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.chunk             (chunk),
		.chunk_bytes       (chunk_bytes),
		.word_length       (word_length),
		.last_chunk        (last_chunk),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Byte classes. Anything with the top bit set counts as a letter.
	// ------------------------------------------------------------------------
	function automatic bit cls_upper(input logic [7:0] c);
		return c >= "A" && c <= "Z";
	endfunction

	function automatic bit cls_lower(input logic [7:0] c);
		return c >= "a" && c <= "z";
	endfunction

	function automatic bit cls_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit cls_letter(input logic [7:0] c);
		return cls_upper(c) || cls_lower(c) || c >= 8'h80;
	endfunction

	function automatic bit cls_alnum(input logic [7:0] c);
		return cls_letter(c) || cls_digit(c);
	endfunction

	// ------------------------------------------------------------------------
	// Word chunk prediction
	// ------------------------------------------------------------------------
	// Closes the open word; a word that passes the limits becomes 8-byte
	// chunks, first byte lowest, unused bytes zero.
	function automatic void emit_word();
		int         pos;
		int         take;
		chunk_rec_t rec;
		if (in_word && open_len >= cfg_min_len && open_len <= WORD_CAP &&
		    open_letters >= cfg_min_letters) begin
			pos = 0;
			while (pos < open_len && chunks_this_item < MAX_CHUNKS_PER_ITEM) begin
				take = (open_len - pos > 8) ? 8 : open_len - pos;
				rec = '0;
				for (int n = 0; n < take; n++)
					rec.data[8*n +: 8] = word_bytes[(pos + n) % 64];
				rec.nbytes = CHUNK_BYTES_W'(take);
				rec.wlen = WORD_LEN_W'(open_len);
				pos += take;
				rec.last = (pos >= open_len);
				expected_chunks.push_back(rec);
				chunks_this_item++;
			end
		end
		open_len = 0;
		open_letters = 0;
		in_word = 1'b0;
	endfunction

	// Length saturates one past the cap, so an over-long word is never cut.
	function automatic void add_to_word(input logic [7:0] c);
		logic [7:0] lc;
		lc = cls_upper(c) ? c + 8'h20 : c;
		if (open_len <= WORD_CAP) begin
			if (open_len < WORD_CAP)
				word_bytes[open_len % 64] = lc;
			if (cls_letter(lc))
				open_letters++;
			open_len++;
		end
		in_word = 1'b1;
	endfunction

	// Word boundary rules: separators, lower/digit then capital, and an
	// acronym followed by a capitalised word (HTTPServer -> http, server).
	function automatic void judge_byte(input logic [7:0] c, input logic [7:0] prev,
	                                   input bit has_next, input logic [7:0] nxt);
		if (!cls_alnum(c)) begin
			if (in_word)
				emit_word();
			return;
		end
		if (in_word && cls_upper(c) &&
		    (cls_lower(prev) || cls_digit(prev) ||
		     (cls_upper(prev) && has_next && cls_lower(nxt))))
			emit_word();
		add_to_word(c);
	endfunction

	// One accepted item: the held byte is judged now that its successor is
	// known; on the final byte everything is flushed.
	function automatic void predict_chunks(input logic [7:0] c, input logic last);
		chunks_this_item = 0;
		if (held_ok) begin
			judge_byte(held, prev_held, 1'b1, c);
			prev_held = held;
		end else begin
			prev_held = 8'h00;
		end
		held = c;
		held_ok = 1'b1;
		if (last) begin
			judge_byte(c, prev_held, 1'b0, 8'h00);
			if (in_word)
				emit_word();
			held = 8'h00;
			held_ok = 1'b0;
			prev_held = 8'h00;
		end
	endfunction

	// ------------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------------
	function automatic void note_fault(input string what, input chunk_rec_t want,
	                                   input chunk_rec_t got);
		fault_count++;
		if (fault_count <= REPORT_LIMIT)
			$display("%0d: %s: expected %h/%0d/%0d/%0d got %h/%0d/%0d/%0d", cycle_count,
			         what, want.data, want.nbytes, want.wlen, want.last,
			         got.data, got.nbytes, got.wlen, got.last);
	endfunction

	always @(posedge clk) begin : chunk_check
		chunk_rec_t got;
		chunk_rec_t want;
		if (arst_n && out_valid && out_ready) begin
			got.data = chunk;
			got.nbytes = chunk_bytes;
			got.wlen = word_length;
			got.last = last_chunk;
			if (expected_chunks.size() == 0) begin
				note_fault("chunk with none expected", '0, got);
			end else begin
				want = expected_chunks.pop_front();
				if (got.data !== want.data || got.nbytes !== want.nbytes ||
				    got.wlen !== want.wlen || got.last !== want.last)
					note_fault("chunk mismatch", want, got);
			end
		end
	end

	// receiver: random stalls unless the flow is held steady
	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("run timed out after %0d cycles", cycle_count);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	// Presents one item and waits for it to be taken. Valid is only lowered
	// for a gap, never dropped and raised within one step.
	task automatic send_byte(input logic [7:0] b, input logic last);
		if (!steady_flow) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		ch <= b;
		end_of_identifier <= last;
		do @(posedge clk); while (!in_ready);
		predict_chunks(b, last);
	endtask

	task automatic send_ident(input byte_seq_t s);
		foreach (s[i])
			send_byte(s[i], i == s.size() - 1);
	endtask

	task automatic send_text(input string t);
		byte_seq_t s;
		for (int i = 0; i < t.len(); i++)
			s.push_back(t[i]);
		send_ident(s);
	endtask

	// Sender pauses until every chunk is out, then lets the block finish
	// any item that produced nothing.
	task automatic drain(input int extra);
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_chunks.size() != 0);
		repeat (extra) @(posedge clk);
	endtask

	// Only called with the block idle and at an identifier boundary.
	task automatic set_limits(input int len_min, input int letters_min);
		cfg_we <= 1'b1;
		cfg_index <= REG_MIN_WORD_LENGTH;
		cfg_data <= CFG_W'(len_min);
		@(posedge clk);
		cfg_min_len = len_min % 64;
		cfg_index <= REG_MIN_LETTER_COUNT;
		cfg_data <= CFG_W'(letters_min);
		@(posedge clk);
		cfg_min_letters = letters_min % 64;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] pick_separator();
		logic [7:0] c;
		do c = 8'($urandom_range(127)); while (cls_alnum(c));
		return c;
	endfunction

	function automatic logic [7:0] pick_run_byte(input run_style_t style, input int k);
		case (style)
			RUN_LOWER:   return 8'("a" + $urandom_range(25));
			RUN_TITLE:   return (k == 0) ? 8'("A" + $urandom_range(25))
			                             : 8'("a" + $urandom_range(25));
			RUN_ACRONYM: return 8'("A" + $urandom_range(25));
			RUN_DIGITS:  return 8'("0" + $urandom_range(9));
			default: begin
				case ($urandom_range(3))
					0:       return 8'("a" + $urandom_range(25));
					1:       return 8'("A" + $urandom_range(25));
					2:       return 8'("0" + $urandom_range(9));
					default: return 8'($urandom_range(128, 255));
				endcase
			end
		endcase
	endfunction

	// Mostly identifiers built from word runs; some raw noise. Now and then
	// a run is long enough to reach or pass the length cap.
	function automatic byte_seq_t random_ident();
		byte_seq_t  s;
		int         len;
		run_style_t style;
		if ($urandom_range(99) < 15) begin
			len = $urandom_range(1, 8);
			repeat (len) s.push_back(8'($urandom_range(255)));
			return s;
		end
		for (int w = $urandom_range(1, 4); w > 0; w--) begin
			if (s.size() != 0 && $urandom_range(2) == 0)
				s.push_back($urandom_range(1) ? 8'h5F : pick_separator());
			len = ($urandom_range(19) == 0) ? $urandom_range(56, 70) : $urandom_range(1, 9);
			style = run_style_t'($urandom_range(4));
			for (int k = 0; k < len; k++)
				s.push_back(pick_run_byte(style, k));
		end
		if ($urandom_range(9) == 0)
			s.push_back(pick_separator());
		return s;
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	// Boundary rules at the reset limits, then every class edge of the byte
	// range with everything kept, then a lone final byte.
	task automatic test_split_rules();
		byte_seq_t sweep = '{8'h00, 8'hFF, 8'h80, 8'h2F, 8'h30, 8'h39, 8'h3A,
		                     8'h41, 8'h5A, 8'h5B, 8'h60, 8'h61, 8'h7A, 8'h7B};
		send_text("fooBar");
		send_text("ABCd");
		drain(SETTLE_CYCLES);
		set_limits(1, 0);
		send_ident(sweep);
		send_text("Q");
	endtask

	// A word of exactly the cap is kept at the strictest limits; one byte
	// more and it goes whole. Run with no idling on either side.
	task automatic test_length_limit();
		byte_seq_t w;
		steady_flow = 1'b1;
		drain(SETTLE_CYCLES);
		set_limits(63, 63);
		for (int i = 0; i < WORD_CAP; i++)
			w.push_back($urandom_range(1) ? 8'("a" + $urandom_range(25))
			                              : 8'($urandom_range(128, 255)));
		send_ident(w);
		w.push_back(8'h7A);
		send_ident(w);
		drain(SETTLE_CYCLES);
		steady_flow = 1'b0;
	endtask

	// Random identifiers across several limit settings; one pause for a full
	// drain part way through each phase.
	task automatic test_random_identifiers(input int item_goal);
		int phase_items;
		int pause_at;
		for (int p = 0; p < 4; p++) begin
			drain(SETTLE_CYCLES);
			case (p)
				0:       set_limits(0, 0);   // zero length acts as one
				1:       set_limits(2, 2);
				2:       set_limits(4, 1);
				default: set_limits($urandom_range(1, 6), $urandom_range(0, 4));
			endcase
			phase_items = 0;
			pause_at = $urandom_range(10, item_goal / 4 - 10);
			while (phase_items < item_goal / 4) begin : one_ident
				byte_seq_t s;
				s = random_ident();
				send_ident(s);
				phase_items += s.size();
				if (pause_at > 0 && phase_items >= pause_at) begin
					drain(0);
					pause_at = 0;
				end
			end
		end
	endtask

	initial begin
		int waited;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_split_rules();
		test_length_limit();
		test_random_identifiers(80);

		// bounded wait for the tail, then a settling pause
		in_valid <= 1'b0;
		waited = 0;
		while (expected_chunks.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (expected_chunks.size() != 0)
			note_fault("chunk never arrived", expected_chunks.pop_front(), '0);

		if (fault_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
